@@ rtl/grcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Gyro rate calibration and filter package
// Shared widths, constants, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package grcdf_pkg;

	localparam int RATE_W     = 20;
	localparam int RATE_MAX   = 512000;
	localparam int SUM_W      = 24;
	localparam int SUM_MAX    = 8388607;
	localparam int SUM_MIN    = -8388608;
	localparam int COUNT_W    = 7;
	localparam int SCALE_W    = 16;
	localparam int ALPHA_W    = 17;
	localparam int DEAD_W     = 16;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int ALPHA_ONE  = 65536;
	localparam int Q_FRAC     = 8;
	localparam int GAIN_FRAC  = 16;

	localparam int SCALE_RESET = 3996;
	localparam int ALPHA_RESET = 13107;
	localparam int DEAD_RESET  = 128;

	localparam int CAL_SAMPLES_DEF = 100;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int MCAND_W  = SUM_W;
	localparam int MPLIER_W = ALPHA_W;
	localparam int DIGIT_W  = 4;

	localparam logic OP_MEASURE   = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE_SCALE     = 2'd0,
		REG_FILTER_ALPHA   = 2'd1,
		REG_DEADBAND_LIMIT = 2'd2
	} grcdf_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_MULR,
		ST_SCALE,
		ST_DEAD,
		ST_DIFF,
		ST_MULF,
		ST_FILT,
		ST_MULC,
		ST_PREP,
		ST_DIV,
		ST_OFS,
		ST_EMIT
	} grcdf_state_t;

endpackage

@@ rtl/gyro_rate_calibrate_deadband_filter.sv @@
// ----------------------------------------------------------------------------
// Gyro rate calibration, deadband and low-pass filter
// A measure item runs through two digit-serial multiplies to the result register.
// A calibration item only accumulates; the last of a run also multiplies and
// runs the serial divider. A new item is taken only in idle, after the last
// one has been emitted.
// Results wait in an output register while the next item is taken.
// Reset clears the filter, offset, calibration sum and count and loads the
// default register values.
// ----------------------------------------------------------------------------
module gyro_rate_calibrate_deadband_filter #(
	parameter int CAL_SAMPLES = grcdf_pkg::CAL_SAMPLES_DEF,
	parameter int SAMPLE_BITS = grcdf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [grcdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [grcdf_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic                                opcode,
	input  logic signed [SAMPLE_BITS-1:0]       raw_rate,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [grcdf_pkg::RATE_W-1:0] filtered_rate,
	output logic                                offset_valid
);

	localparam int RATE_W   = grcdf_pkg::RATE_W;
	localparam int SUM_W    = grcdf_pkg::SUM_W;
	localparam int COUNT_W  = grcdf_pkg::COUNT_W;
	localparam int MCAND_W  = grcdf_pkg::MCAND_W;
	localparam int MPLIER_W = grcdf_pkg::MPLIER_W;
	localparam int PROD_W   = MCAND_W + MPLIER_W;
	localparam int WIDE_W   = PROD_W + 1;
	localparam int DIV_W    = PROD_W - grcdf_pkg::Q_FRAC;
	localparam int OFS_BIAS = CAL_SAMPLES * (1 << grcdf_pkg::Q_FRAC);

	localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(grcdf_pkg::RATE_MAX);
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_MAX;
	localparam logic signed [WIDE_W-1:0] Q8_HALF  = WIDE_W'(1 << (grcdf_pkg::Q_FRAC - 1));
	localparam logic signed [WIDE_W-1:0] G_HALF   = WIDE_W'(1 << (grcdf_pkg::GAIN_FRAC - 1));
	localparam logic signed [WIDE_W-1:0] BIAS_W   = WIDE_W'(OFS_BIAS);
	localparam logic signed [WIDE_W-1:0] CEIL_ADJ = WIDE_W'(CAL_SAMPLES - 1);
	localparam logic signed [RATE_W:0]   DIFF_MAX = (RATE_W + 1)'(grcdf_pkg::RATE_MAX);
	localparam logic signed [RATE_W:0]   DIFF_MIN = -DIFF_MAX;
	localparam logic signed [RATE_W-1:0] R_MAX    = RATE_W'(grcdf_pkg::RATE_MAX);
	localparam logic signed [SUM_W:0]    S_MAX    = (SUM_W + 1)'(grcdf_pkg::SUM_MAX);
	localparam logic signed [SUM_W:0]    S_MIN    = (SUM_W + 1)'(grcdf_pkg::SUM_MIN);
	localparam logic [DIV_W-1:0]         Q_MAX    = DIV_W'(grcdf_pkg::RATE_MAX);
	localparam logic [MPLIER_W-1:0]      A_ONE    = MPLIER_W'(grcdf_pkg::ALPHA_ONE);

	grcdf_pkg::grcdf_state_t state_q, state_d;

	logic [grcdf_pkg::SCALE_W-1:0] scale_q;
	logic [grcdf_pkg::ALPHA_W-1:0] alpha_q;
	logic [grcdf_pkg::DEAD_W-1:0]  dead_q;

	logic signed [RATE_W-1:0]      filt_q;
	logic signed [RATE_W-1:0]      offset_q;
	logic signed [SUM_W-1:0]       cal_sum_q;
	logic        [COUNT_W-1:0]     cal_count_q;
	logic                          offset_done_q;

	logic signed [SAMPLE_BITS-1:0] raw_q;
	logic signed [RATE_W-1:0]      scaled_q;
	logic signed [RATE_W-1:0]      v_q;
	logic                          neg_q;
	logic                          result_valid_q;
	logic signed [RATE_W-1:0]      result_rate_q;
	logic                          result_flag_q;

	logic                          out_free;
	logic                          load_result;
	logic                          mult_start;
	logic signed [MCAND_W-1:0]     mult_mcand;
	logic        [MPLIER_W-1:0]    mult_mplier;
	logic signed [PROD_W-1:0]      mult_prod;
	logic                          mult_done;
	logic                          div_start;
	logic        [DIV_W-1:0]       div_quot;
	logic                          div_done;

	logic signed [SUM_W:0]         sum_ext;
	logic signed [SUM_W-1:0]       sum_sat;
	logic        [COUNT_W-1:0]     count_next;
	logic                          cal_complete;
	logic        [MPLIER_W-1:0]    alpha_eff;

	logic signed [WIDE_W-1:0]      prod_ext;
	logic signed [WIDE_W-1:0]      sc_shift;
	logic signed [RATE_W-1:0]      sc_sat;
	logic signed [RATE_W:0]        diff;
	logic signed [RATE_W-1:0]      v_sat;
	logic signed [RATE_W:0]        v_mag;
	logic signed [RATE_W:0]        d_filt;
	logic signed [WIDE_W-1:0]      f_shift;
	logic signed [RATE_W-1:0]      f_sat;
	logic signed [WIDE_W-1:0]      ofs_m;
	logic signed [WIDE_W-1:0]      ofs_t;
	logic signed [WIDE_W-1:0]      ofs_u;
	logic signed [RATE_W-1:0]      ofs_res;

	// Calibration accumulate with saturation to the sum range.
	assign sum_ext      = (SUM_W + 1)'(cal_sum_q) + (SUM_W + 1)'(raw_q);
	assign sum_sat      = (sum_ext > S_MAX) ? S_MAX[SUM_W-1:0] :
	                      (sum_ext < S_MIN) ? S_MIN[SUM_W-1:0] : sum_ext[SUM_W-1:0];
	assign count_next   = cal_count_q + COUNT_W'(1);
	assign cal_complete = count_next >= COUNT_W'(CAL_SAMPLES);
	assign alpha_eff    = (alpha_q > A_ONE) ? A_ONE : alpha_q;

	// Scale to Q.8 with round to nearest.
	assign prod_ext = WIDE_W'(mult_prod);
	assign sc_shift = (prod_ext + Q8_HALF) >>> grcdf_pkg::Q_FRAC;
	assign sc_sat   = (sc_shift > WIDE_MAX) ? R_MAX :
	                  (sc_shift < WIDE_MIN) ? -R_MAX : sc_shift[RATE_W-1:0];

	// Offset removal and deadband.
	assign diff  = (RATE_W + 1)'(scaled_q) - (RATE_W + 1)'(offset_q);
	assign v_sat = (diff > DIFF_MAX) ? R_MAX :
	               (diff < DIFF_MIN) ? -R_MAX : diff[RATE_W-1:0];
	assign v_mag = v_sat[RATE_W-1] ? -((RATE_W + 1)'(v_sat)) : (RATE_W + 1)'(v_sat);

	// The filter update is filtered + (value - filtered) * alpha.
	assign d_filt  = (RATE_W + 1)'(v_q) - (RATE_W + 1)'(filt_q);
	assign f_shift = ((WIDE_W'(filt_q) <<< grcdf_pkg::GAIN_FRAC) + prod_ext + G_HALF)
	                 >>> grcdf_pkg::GAIN_FRAC;
	assign f_sat   = (f_shift > WIDE_MAX) ? R_MAX :
	                 (f_shift < WIDE_MIN) ? -R_MAX : f_shift[RATE_W-1:0];

	// The rounded mean is floor(floor((2n + D) / 512) / CAL_SAMPLES).
	assign ofs_m = (prod_ext <<< 1) + BIAS_W;
	assign ofs_t = ofs_m >>> (grcdf_pkg::Q_FRAC + 1);
	assign ofs_u = ofs_t[WIDE_W-1] ? (CEIL_ADJ - ofs_t) : ofs_t;

	assign ofs_res = (div_quot > Q_MAX) ? (neg_q ? -R_MAX : R_MAX) :
	                 (neg_q ? -(div_quot[RATE_W-1:0]) : div_quot[RATE_W-1:0]);

	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grcdf_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = (opcode == grcdf_pkg::OP_CALIBRATE) ? grcdf_pkg::ST_ACC :
					          grcdf_pkg::ST_MULR;
				end
			end
			grcdf_pkg::ST_ACC: begin
				state_d = cal_complete ? grcdf_pkg::ST_MULC : grcdf_pkg::ST_EMIT;
			end
			grcdf_pkg::ST_MULR: begin
				if (mult_done) begin
					state_d = grcdf_pkg::ST_SCALE;
				end
			end
			grcdf_pkg::ST_SCALE: state_d = grcdf_pkg::ST_DEAD;
			grcdf_pkg::ST_DEAD:  state_d = grcdf_pkg::ST_DIFF;
			grcdf_pkg::ST_DIFF:  state_d = grcdf_pkg::ST_MULF;
			grcdf_pkg::ST_MULF: begin
				if (mult_done) begin
					state_d = grcdf_pkg::ST_FILT;
				end
			end
			grcdf_pkg::ST_FILT: state_d = grcdf_pkg::ST_EMIT;
			grcdf_pkg::ST_MULC: begin
				if (mult_done) begin
					state_d = grcdf_pkg::ST_PREP;
				end
			end
			grcdf_pkg::ST_PREP: state_d = grcdf_pkg::ST_DIV;
			grcdf_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = grcdf_pkg::ST_OFS;
				end
			end
			grcdf_pkg::ST_OFS: state_d = grcdf_pkg::ST_EMIT;
			grcdf_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = grcdf_pkg::ST_IDLE;
				end
			end
			default: state_d = grcdf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		mult_start   = 1'b0;
		mult_mcand   = MCAND_W'(raw_rate);
		mult_mplier  = MPLIER_W'(scale_q);
		div_start    = 1'b0;
		load_result  = 1'b0;
		unique case (state_q)
			grcdf_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				mult_start   = sample_valid && (opcode == grcdf_pkg::OP_MEASURE);
			end
			grcdf_pkg::ST_ACC: begin
				mult_start = cal_complete;
				mult_mcand = sum_sat;
			end
			grcdf_pkg::ST_DIFF: begin
				mult_start  = 1'b1;
				mult_mcand  = MCAND_W'(d_filt);
				mult_mplier = alpha_eff;
			end
			grcdf_pkg::ST_PREP: begin
				div_start = 1'b1;
			end
			grcdf_pkg::ST_EMIT: begin
				load_result = out_free;
			end
			default: begin
				sample_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= grcdf_pkg::ST_IDLE;
			scale_q        <= grcdf_pkg::SCALE_W'(grcdf_pkg::SCALE_RESET);
			alpha_q        <= grcdf_pkg::ALPHA_W'(grcdf_pkg::ALPHA_RESET);
			dead_q         <= grcdf_pkg::DEAD_W'(grcdf_pkg::DEAD_RESET);
			filt_q         <= '0;
			offset_q       <= '0;
			cal_sum_q      <= '0;
			cal_count_q    <= '0;
			offset_done_q  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					grcdf_pkg::REG_RATE_SCALE:     scale_q <= cfg_data[grcdf_pkg::SCALE_W-1:0];
					grcdf_pkg::REG_FILTER_ALPHA:   alpha_q <= cfg_data[grcdf_pkg::ALPHA_W-1:0];
					grcdf_pkg::REG_DEADBAND_LIMIT: dead_q  <= cfg_data[grcdf_pkg::DEAD_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == grcdf_pkg::ST_ACC) begin
				if (cal_complete) begin
					cal_sum_q   <= '0;
					cal_count_q <= '0;
				end else begin
					cal_sum_q   <= sum_sat;
					cal_count_q <= count_next;
				end
			end
			if (state_q == grcdf_pkg::ST_FILT) begin
				filt_q <= f_sat;
			end
			if (state_q == grcdf_pkg::ST_OFS) begin
				offset_q      <= ofs_res;
				offset_done_q <= 1'b1;
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == grcdf_pkg::ST_IDLE) begin
			raw_q <= raw_rate;
		end
		if (state_q == grcdf_pkg::ST_SCALE) begin
			scaled_q <= sc_sat;
		end
		if (state_q == grcdf_pkg::ST_DEAD) begin
			v_q <= (v_mag < (RATE_W + 1)'(dead_q)) ? '0 : v_sat;
		end
		if (state_q == grcdf_pkg::ST_PREP) begin
			neg_q <= ofs_t[WIDE_W-1];
		end
		if (load_result) begin
			result_rate_q <= filt_q;
			result_flag_q <= offset_done_q;
		end
	end

	grcdf_serial_mult #(
		.MCAND_W  (MCAND_W),
		.MPLIER_W (MPLIER_W),
		.DIGIT_W  (grcdf_pkg::DIGIT_W)
	) u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mult_start),
		.mcand   (mult_mcand),
		.mplier  (mult_mplier),
		.product (mult_prod),
		.done    (mult_done)
	);

	grcdf_const_div #(
		.NUM_W   (DIV_W),
		.DIVISOR (CAL_SAMPLES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ofs_u[DIV_W-1:0]),
		.quotient (div_quot),
		.done     (div_done)
	);

	assign result_valid  = result_valid_q;
	assign filtered_rate = result_rate_q;
	assign offset_valid  = result_flag_q;

	// A multiply finishes only while the controller waits for it.
	a_mult_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mult_done |-> (state_q == grcdf_pkg::ST_MULR || state_q == grcdf_pkg::ST_MULF ||
		               state_q == grcdf_pkg::ST_MULC))
		else $error("multiplier finished outside a wait state");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == grcdf_pkg::ST_DIV)
		else $error("divider finished outside its wait state");

	a_offset_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		offset_done_q |=> offset_done_q)
		else $error("offset valid flag cleared");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q < COUNT_W'(CAL_SAMPLES))
		else $error("calibration count reached the run length");

endmodule

@@ rtl/grcdf_serial_mult.sv @@
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier digit per cycle.
// ----------------------------------------------------------------------------
module grcdf_serial_mult #(
	parameter int MCAND_W  = grcdf_pkg::MCAND_W,
	parameter int MPLIER_W = grcdf_pkg::MPLIER_W,
	parameter int DIGIT_W  = grcdf_pkg::DIGIT_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [MCAND_W-1:0]           mcand,
	input  logic        [MPLIER_W-1:0]          mplier,
	output logic signed [MCAND_W+MPLIER_W-1:0]  product,
	output logic                                done
);

	localparam int PROD_W = MCAND_W + MPLIER_W;
	localparam int NDIG   = (MPLIER_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W  = NDIG * DIGIT_W;
	localparam int CNT_W  = $clog2(NDIG + 1);

	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] mcand_q;
	logic        [PAD_W-1:0]  mplier_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [PROD_W-1:0] pp;

	assign pp = mcand_q * $signed({1'b0, mplier_q[DIGIT_W-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDIG);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(mcand);
			mplier_q <= PAD_W'(mplier);
		end else if (busy_q) begin
			acc_q    <= acc_q + pp;
			mcand_q  <= mcand_q <<< DIGIT_W;
			mplier_q <= mplier_q >> DIGIT_W;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

@@ rtl/grcdf_const_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial divider by a constant
// Restoring division of an unsigned value, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grcdf_const_div #(
	parameter int NUM_W   = 33,
	parameter int DIVISOR = grcdf_pkg::CAL_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);

	localparam int DV_W  = $clog2(DIVISOR + 1);
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [DV_W:0] DIV_V = (DV_W + 1)'(DIVISOR);

	logic [NUM_W-1:0] num_q;
	logic [DV_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DV_W:0]    trial;
	logic [DV_W:0]    trial_sub;
	logic             ge;

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign ge        = trial >= DIV_V;
	assign trial_sub = trial - DIV_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? trial_sub[DV_W-1:0] : trial[DV_W-1:0];
		end
	end

	assign quotient = num_q;
	assign done     = done_q;

endmodule

@@ bench/gyro_rate_calibrate_deadband_filter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gyro rate calibration and filter testbench
// A short table of directed items and register writes, then random phases
// with calibration runs and measure samples under three idling patterns.
// Results are checked against a bit-exact predictor or a table row's value.
// ----------------------------------------------------------------------------
module gyro_rate_calibrate_deadband_filter_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_GAP      = 40;

	typedef struct packed {
		logic               rate_sign_dummy;
		logic signed [19:0] rate;
		logic               valid;
	} gyro_result_t;

	typedef struct packed {
		logic                  is_cfg;
		grcdf_pkg::grcdf_reg_t reg_sel;
		logic [16:0]           cfg_value;
		logic                  op;
		logic signed [15:0]    raw;
		logic                  typed;
		logic signed [19:0]    exp_rate;
		logic                  exp_valid;
	} stim_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_write;
	logic [grcdf_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [grcdf_pkg::CFG_W-1:0]         cfg_data;
	logic                                sample_valid;
	logic                                sample_stall;
	logic                                opcode;
	logic signed [15:0]                  raw_rate;
	logic                                result_valid;
	logic                                result_stall;
	logic signed [grcdf_pkg::RATE_W-1:0] filtered_rate;
	logic                                offset_valid;

	gyro_result_t expected_results[$];
	stim_row_t    stim_rows[$];
	int           errors;
	int           cycle_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	bit           hold_req;

	longint scale_cfg;
	longint alpha_cfg;
	longint dead_cfg;
	longint filt_acc;
	longint zero_ofs;
	longint cal_acc;
	int     cal_cnt;
	bit     ofs_ready;

	gyro_rate_calibrate_deadband_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.opcode        (opcode),
		.raw_rate      (raw_rate),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.filtered_rate (filtered_rate),
		.offset_valid  (offset_valid)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint div_floor(longint n, longint d);
		if (n >= 0) begin
			return n / d;
		end
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint div_nearest(longint n, longint d);
		return div_floor(2 * n + d, 2 * d);
	endfunction

	function automatic longint clamp_rate(longint x);
		if (x > grcdf_pkg::RATE_MAX) begin
			return grcdf_pkg::RATE_MAX;
		end
		if (x < -grcdf_pkg::RATE_MAX) begin
			return -grcdf_pkg::RATE_MAX;
		end
		return x;
	endfunction

	function automatic gyro_result_t filter_step(logic op, logic signed [15:0] raw);
		gyro_result_t r;
		longint       a;
		longint       v;
		longint       mag;
		if (op == grcdf_pkg::OP_CALIBRATE) begin
			cal_acc = cal_acc + longint'(raw);
			if (cal_acc > grcdf_pkg::SUM_MAX) begin
				cal_acc = grcdf_pkg::SUM_MAX;
			end
			if (cal_acc < grcdf_pkg::SUM_MIN) begin
				cal_acc = grcdf_pkg::SUM_MIN;
			end
			cal_cnt = (cal_cnt + 1) & 127;
			if (cal_cnt >= grcdf_pkg::CAL_SAMPLES_DEF) begin
				zero_ofs = clamp_rate(div_nearest(cal_acc * scale_cfg,
					longint'(grcdf_pkg::CAL_SAMPLES_DEF) * 256));
				cal_acc = 0;
				cal_cnt = 0;
				ofs_ready = 1'b1;
			end
		end else begin
			a = (alpha_cfg > grcdf_pkg::ALPHA_ONE) ? longint'(grcdf_pkg::ALPHA_ONE) :
				alpha_cfg;
			v = clamp_rate(div_nearest(longint'(raw) * scale_cfg, 256));
			v = clamp_rate(v - zero_ofs);
			mag = (v < 0) ? -v : v;
			if (mag < dead_cfg) begin
				v = 0;
			end
			filt_acc = clamp_rate(div_nearest(filt_acc * (grcdf_pkg::ALPHA_ONE - a) + v * a,
				grcdf_pkg::ALPHA_ONE));
		end
		r.rate_sign_dummy = 1'b0;
		r.rate = filt_acc[19:0];
		r.valid = ofs_ready;
		return r;
	endfunction

	task automatic row_cfg(grcdf_pkg::grcdf_reg_t sel, int unsigned value);
		stim_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_sel = sel;
		row.cfg_value = value[16:0];
		stim_rows.push_back(row);
	endtask

	task automatic row_item(logic op, int raw);
		stim_row_t row;
		row = '0;
		row.op = op;
		row.raw = raw[15:0];
		stim_rows.push_back(row);
	endtask

	task automatic row_check(logic op, int raw, int rate, logic valid);
		stim_row_t row;
		row = '0;
		row.op = op;
		row.raw = raw[15:0];
		row.typed = 1'b1;
		row.exp_rate = rate[19:0];
		row.exp_valid = valid;
		stim_rows.push_back(row);
	endtask

	task automatic send_item(logic op, logic signed [15:0] raw, logic typed,
		gyro_result_t typed_result);
		int           gap;
		gyro_result_t predicted;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
			gap++;
		end
		cfg_write <= 1'b0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		opcode <= op;
		raw_rate <= raw;
		do begin
			@(posedge clk);
		end while (sample_stall);
		predicted = filter_step(op, raw);
		expected_results.push_back(typed ? typed_result : predicted);
	endtask

	task automatic write_reg(grcdf_pkg::grcdf_reg_t sel, int unsigned value);
		sample_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value[grcdf_pkg::CFG_W-1:0];
		unique case (sel)
			grcdf_pkg::REG_RATE_SCALE:     scale_cfg = value & 32'hFFFF;
			grcdf_pkg::REG_FILTER_ALPHA:   alpha_cfg = value & 32'h1FFFF;
			grcdf_pkg::REG_DEADBAND_LIMIT: dead_cfg = value & 32'hFFFF;
			default:                       ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(int k);
		unique case (k)
			0: begin
				write_reg(grcdf_pkg::REG_RATE_SCALE, 65535);
				write_reg(grcdf_pkg::REG_FILTER_ALPHA, grcdf_pkg::ALPHA_ONE);
				write_reg(grcdf_pkg::REG_DEADBAND_LIMIT, 0);
			end
			1: begin
				write_reg(grcdf_pkg::REG_RATE_SCALE, 1);
				write_reg(grcdf_pkg::REG_FILTER_ALPHA, 131071);
				write_reg(grcdf_pkg::REG_DEADBAND_LIMIT, 65535);
			end
			4: begin
				write_reg(grcdf_pkg::REG_RATE_SCALE, grcdf_pkg::SCALE_RESET);
				write_reg(grcdf_pkg::REG_FILTER_ALPHA, grcdf_pkg::ALPHA_RESET);
				write_reg(grcdf_pkg::REG_DEADBAND_LIMIT, grcdf_pkg::DEAD_RESET);
			end
			default: begin
				write_reg(grcdf_pkg::REG_RATE_SCALE, $urandom_range(1, 65535));
				write_reg(grcdf_pkg::REG_FILTER_ALPHA, $urandom_range(0, 131071));
				write_reg(grcdf_pkg::REG_DEADBAND_LIMIT, $urandom_range(0, 2047));
			end
		endcase
	endtask

	function automatic logic signed [15:0] pick_raw(int near_pct, int bias);
		int sel;
		int v;
		sel = $urandom_range(0, 99);
		if (sel < near_pct) begin
			v = bias + int'($urandom_range(0, 256)) - 128;
			if (v > 32767) begin
				v = 32767;
			end
			if (v < -32768) begin
				v = -32768;
			end
		end else if (sel < near_pct + 5) begin
			v = 32767;
		end else if (sel < near_pct + 10) begin
			v = -32768;
		end else begin
			v = $urandom;
		end
		return v[15:0];
	endfunction

	task automatic run_phase(int count, int cal_pct, int bias);
		logic op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 99) < cal_pct) ? grcdf_pkg::OP_CALIBRATE :
				grcdf_pkg::OP_MEASURE;
			send_item(op, pick_raw((op == grcdf_pkg::OP_CALIBRATE) ? 85 : 30, bias),
				1'b0, '0);
		end
	endtask

	initial begin
		int           bias;
		gyro_result_t typed_result;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= grcdf_pkg::REG_RATE_SCALE;
		cfg_data <= '0;
		sample_valid <= 1'b0;
		opcode <= grcdf_pkg::OP_MEASURE;
		raw_rate <= '0;
		hold_req = 1'b0;
		send_idle_pct = 18;
		recv_stall_pct = 74;
		scale_cfg = grcdf_pkg::SCALE_RESET;
		alpha_cfg = grcdf_pkg::ALPHA_RESET;
		dead_cfg = grcdf_pkg::DEAD_RESET;
		filt_acc = 0;
		zero_ofs = 0;
		cal_acc = 0;
		cal_cnt = 0;
		ofs_ready = 1'b0;

		row_check(grcdf_pkg::OP_MEASURE, 0, 0, 1'b0);
		row_item(grcdf_pkg::OP_MEASURE, 32767);
		row_item(grcdf_pkg::OP_MEASURE, -32768);
		row_item(grcdf_pkg::OP_CALIBRATE, 1234);
		row_item(grcdf_pkg::OP_CALIBRATE, -32768);
		row_cfg(grcdf_pkg::REG_RATE_SCALE, 256);
		row_cfg(grcdf_pkg::REG_FILTER_ALPHA, 131071);
		row_cfg(grcdf_pkg::REG_DEADBAND_LIMIT, 0);
		row_check(grcdf_pkg::OP_MEASURE, 32767, 32767, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, -32768, -32768, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, 0, 0, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, 1, 1, 1'b0);
		row_check(grcdf_pkg::OP_CALIBRATE, 5, 1, 1'b0);
		row_cfg(grcdf_pkg::REG_DEADBAND_LIMIT, 100);
		row_check(grcdf_pkg::OP_MEASURE, 100, 100, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, 99, 0, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, -100, -100, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, -99, 0, 1'b0);
		row_cfg(grcdf_pkg::REG_RATE_SCALE, 65535);
		row_check(grcdf_pkg::OP_MEASURE, 32767, grcdf_pkg::RATE_MAX, 1'b0);
		row_check(grcdf_pkg::OP_MEASURE, -32768, -grcdf_pkg::RATE_MAX, 1'b0);
		row_cfg(grcdf_pkg::REG_FILTER_ALPHA, 0);
		row_check(grcdf_pkg::OP_MEASURE, 12345, -grcdf_pkg::RATE_MAX, 1'b0);
		row_cfg(grcdf_pkg::REG_RATE_SCALE, 1);
		row_cfg(grcdf_pkg::REG_FILTER_ALPHA, 32768);
		row_cfg(grcdf_pkg::REG_DEADBAND_LIMIT, 0);
		row_item(grcdf_pkg::OP_MEASURE, -32768);
		row_item(grcdf_pkg::OP_MEASURE, 255);
		row_item(grcdf_pkg::OP_CALIBRATE, 32767);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				write_reg(stim_rows[i].reg_sel, stim_rows[i].cfg_value);
			end else begin
				typed_result.rate_sign_dummy = 1'b0;
				typed_result.rate = stim_rows[i].exp_rate;
				typed_result.valid = stim_rows[i].exp_valid;
				send_item(stim_rows[i].op, stim_rows[i].raw, stim_rows[i].typed,
					typed_result);
			end
		end

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 74 : 0;
			recv_stall_pct = (mode == 0) ? 74 : (mode == 1) ? 18 : 0;
			apply_setting(2 * mode);
			if (mode == 2) begin
				hold_req = 1'b1;
			end
			bias = (mode == 0) ? 32000 : int'($urandom_range(0, 6000)) - 3000;
			run_phase(120, 90, bias);
			apply_setting(2 * mode + 1);
			run_phase(60, 10, bias);
		end

		sample_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("** gyro_rate_calibrate_deadband_filter: PASSED **");
		end else begin
			$display("** gyro_rate_calibrate_deadband_filter: FAILED **");
		end
		$finish;
	end

	initial begin
		gyro_result_t want;
		int           hold_left;
		bit           hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		errors = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result with nothing pending: rate %0d valid %0b",
							$realtime, filtered_rate, offset_valid);
					end
				end else begin
					want = expected_results.pop_front();
					if (filtered_rate !== want.rate || offset_valid !== want.valid) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch: rate %0d/%0d valid %0b/%0b (exp/got)",
								$realtime, want.rate, filtered_rate, want.valid,
								offset_valid);
						end
					end
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** gyro_rate_calibrate_deadband_filter: FAILED **");
		$finish;
	end

endmodule
